FILE: hw/rtl/rbd_pkg.sv
// Shared constants, register codes and pipeline word types for the rounded box distance block.
package rbd_pkg;

  localparam int unsigned FRAC_BITS = 12;

  localparam int unsigned REG_W  = 15;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned DIST_W = 18;
  localparam int unsigned Q_W    = 18;
  localparam int unsigned ROOT_W = 17;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned OFF_W  = 18;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [REG_W-1:0] HALF_RESET = REG_W'(1 << FRAC_BITS);

  localparam logic [IDX_W-1:0] REG_HALF_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HALF_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_RAD_UR      = 3'd2;
  localparam logic [IDX_W-1:0] REG_RAD_LR      = 3'd3;
  localparam logic [IDX_W-1:0] REG_RAD_UL      = 3'd4;
  localparam logic [IDX_W-1:0] REG_RAD_LL      = 3'd5;

  typedef struct packed {
    logic [REG_W-1:0] half_width;
    logic [REG_W-1:0] half_height;
    logic [REG_W-1:0] rad_ur;
    logic [REG_W-1:0] rad_lr;
    logic [REG_W-1:0] rad_ul;
    logic [REG_W-1:0] rad_ll;
  } shape_cfg_t;

  // word handed from cell to cell of the square root chain
  typedef struct packed {
    logic [RAD_W-1:0]        rad;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic signed [OFF_W-1:0] off;
  } sqr_t;

endpackage

FILE: hw/rtl/rounded_box_distance_eval.sv
// Top level of the rounded box signed distance evaluator.
// Usage:
//   in_*  : stream of points, one word per point, pos_x and pos_y in Q3.12.
//   out_* : stream of distances, one word per point, in Q5.12, same order.
//   cfg_* : APB-style register port; half extents and the four corner radii.
//           Write registers only while no points are in flight.
// Pipeline: input acceptance reaches out_tvalid through 3 front stages,
//   17 square root cells and 1 output register.
// Throughput: one point per cycle; each square root cell holds one point and
//   settles one root bit, so a new point enters every cycle while the output drains.
// Stall: when out_tready is low the chain keeps filling its empty stages and
//   in_tready drops only when every stage holds a word.
// Reset (rst_n low, synchronous): all stages empty, half extents 1.0,
//   radii 0.
module rounded_box_distance_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,    // pos_x[15:0], pos_y[31:16]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,   // distance[17:0], zero[23:18]
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rbd_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [rbd_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [rbd_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int unsigned NCELL = rbd_pkg::ROOT_W;

  rbd_pkg::shape_cfg_t cfg_r;
  logic [rbd_pkg::IDX_W-1:0] idx;
  logic wr;
  logic [rbd_pkg::REG_W-1:0] wval;
  logic [rbd_pkg::REG_W-1:0] rval;

  logic          ch_valid [NCELL+1];
  logic          ch_ready [NCELL+1];
  rbd_pkg::sqr_t ch_data  [NCELL+1];

  logic signed [rbd_pkg::DIST_W-1:0] dist_val;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[rbd_pkg::ADDR_W-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wval       = cfg_pwdata[rbd_pkg::REG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width  <= rbd_pkg::HALF_RESET;
      cfg_r.half_height <= rbd_pkg::HALF_RESET;
      cfg_r.rad_ur      <= '0;
      cfg_r.rad_lr      <= '0;
      cfg_r.rad_ul      <= '0;
      cfg_r.rad_ll      <= '0;
    end else if (wr) begin
      case (idx)
        rbd_pkg::REG_HALF_WIDTH:  cfg_r.half_width  <= wval;
        rbd_pkg::REG_HALF_HEIGHT: cfg_r.half_height <= wval;
        rbd_pkg::REG_RAD_UR:      cfg_r.rad_ur      <= wval;
        rbd_pkg::REG_RAD_LR:      cfg_r.rad_lr      <= wval;
        rbd_pkg::REG_RAD_UL:      cfg_r.rad_ul      <= wval;
        rbd_pkg::REG_RAD_LL:      cfg_r.rad_ll      <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rbd_pkg::REG_HALF_WIDTH:  rval = cfg_r.half_width;
      rbd_pkg::REG_HALF_HEIGHT: rval = cfg_r.half_height;
      rbd_pkg::REG_RAD_UR:      rval = cfg_r.rad_ur;
      rbd_pkg::REG_RAD_LR:      rval = cfg_r.rad_lr;
      rbd_pkg::REG_RAD_UL:      rval = cfg_r.rad_ul;
      rbd_pkg::REG_RAD_LL:      rval = cfg_r.rad_ll;
      default:                  rval = '0;
    endcase
  end

  assign cfg_prdata = rbd_pkg::DATA_W'(rval);

  rbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .pos_x    ($signed(in_tdata[15:0])),
    .pos_y    ($signed(in_tdata[31:16])),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_data  (ch_data[0])
  );

  // cell j settles root bit NCELL-1-j, most significant first
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    rbd_sqrt_cell #(
      .DIGIT (NCELL - 1 - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[j]),
      .up_ready (ch_ready[j]),
      .up_data  (ch_data[j]),
      .dn_valid (ch_valid[j+1]),
      .dn_ready (ch_ready[j+1]),
      .dn_data  (ch_data[j+1])
    );
  end

  rbd_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ch_valid[NCELL]),
    .up_ready (ch_ready[NCELL]),
    .up_data  (ch_data[NCELL]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .distance (dist_val)
  );

  assign out_tdata = {6'b000000, dist_val};

endmodule

FILE: hw/rtl/rbd_front.sv
// Front pipeline: folds the point into q, squares the positive parts, forms the radicand and offset.
module rbd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rbd_pkg::shape_cfg_t            cfg,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [rbd_pkg::POS_W-1:0] pos_x,
  input  logic signed [rbd_pkg::POS_W-1:0] pos_y,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output rbd_pkg::sqr_t                  dn_data
);

  // stage 1: q vector and radius
  logic                                v1_r;
  logic signed [rbd_pkg::Q_W-1:0]      qx_r, qy_r;
  logic [rbd_pkg::REG_W-1:0]           r1_r;
  // stage 2: squares and offset
  logic                                v2_r;
  logic [2*rbd_pkg::POS_W-1:0]         sqx_r, sqy_r;
  logic signed [rbd_pkg::OFF_W-1:0]    off2_r;
  // stage 3: radicand
  logic                                v3_r;
  rbd_pkg::sqr_t                       d3_r;

  logic rdy1, rdy2, rdy3;

  logic signed [rbd_pkg::POS_W:0]  xs, ys;
  logic [rbd_pkg::POS_W:0]         ax, ay;
  logic                            x_pos, y_pos;
  logic [rbd_pkg::REG_W-1:0]       r_sel;
  logic signed [rbd_pkg::Q_W-1:0]  qx_nxt, qy_nxt;

  logic [rbd_pkg::POS_W-1:0]       px, py;
  logic signed [rbd_pkg::Q_W-1:0]  qmax, inner;
  logic signed [rbd_pkg::OFF_W-1:0] off_nxt;
  logic [rbd_pkg::RAD_W-1:0]       rad_nxt;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;
  assign dn_data  = d3_r;

  always_comb begin
    xs     = {pos_x[rbd_pkg::POS_W-1], pos_x};
    ys     = {pos_y[rbd_pkg::POS_W-1], pos_y};
    ax     = xs[rbd_pkg::POS_W] ? 17'(-xs) : 17'(xs);
    ay     = ys[rbd_pkg::POS_W] ? 17'(-ys) : 17'(ys);
    x_pos  = !pos_x[rbd_pkg::POS_W-1] && (pos_x != '0);
    y_pos  = !pos_y[rbd_pkg::POS_W-1] && (pos_y != '0);
    if (x_pos) begin
      r_sel = y_pos ? cfg.rad_ur : cfg.rad_lr;
    end else begin
      r_sel = y_pos ? cfg.rad_ul : cfg.rad_ll;
    end
    qx_nxt = $signed({1'b0, ax}) - $signed({3'b000, cfg.half_width})
             + $signed({3'b000, r_sel});
    qy_nxt = $signed({1'b0, ay}) - $signed({3'b000, cfg.half_height})
             + $signed({3'b000, r_sel});
  end

  always_comb begin
    px      = qx_r[rbd_pkg::Q_W-1] ? '0 : qx_r[rbd_pkg::POS_W-1:0];
    py      = qy_r[rbd_pkg::Q_W-1] ? '0 : qy_r[rbd_pkg::POS_W-1:0];
    qmax    = (qx_r > qy_r) ? qx_r : qy_r;
    inner   = qmax[rbd_pkg::Q_W-1] ? qmax : '0;
    off_nxt = inner - $signed({3'b000, r1_r});
    rad_nxt = rbd_pkg::RAD_W'(sqx_r) + rbd_pkg::RAD_W'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
      r1_r <= r_sel;
    end
    if (rdy2 && v1_r) begin
      sqx_r  <= px * px;
      sqy_r  <= py * py;
      off2_r <= off_nxt;
    end
    if (rdy3 && v2_r) begin
      d3_r.rad  <= rad_nxt;
      d3_r.rem  <= '0;
      d3_r.root <= '0;
      d3_r.off  <= off2_r;
    end
  end

endmodule

FILE: hw/rtl/rbd_sqrt_cell.sv
// One cell of the square root chain: settles one root bit from one radicand bit pair.
module rbd_sqrt_cell #(
  parameter int unsigned DIGIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  rbd_pkg::sqr_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output rbd_pkg::sqr_t dn_data
);

  logic          v_r;
  rbd_pkg::sqr_t d_r;
  rbd_pkg::sqr_t d_nxt;

  logic [rbd_pkg::REM_W-1:0] rem_sh, trial;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    rem_sh = {up_data.rem[rbd_pkg::REM_W-3:0], up_data.rad[2*DIGIT+1 -: 2]};
    trial  = {up_data.root, 2'b01};
    d_nxt  = up_data;
    if (rem_sh >= trial) begin
      d_nxt.rem  = rem_sh - trial;
      d_nxt.root = {up_data.root[rbd_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh;
      d_nxt.root = {up_data.root[rbd_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) d_r <= d_nxt;
  end

endmodule

FILE: hw/rtl/rbd_tail.sv
// Output stage: adds root and offset, saturates, holds the result word.
module rbd_tail (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  rbd_pkg::sqr_t                    up_data,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [rbd_pkg::DIST_W-1:0] distance
);

  logic                              v_r;
  logic signed [rbd_pkg::DIST_W-1:0] dist_r;
  logic signed [rbd_pkg::DIST_W:0]   sum;
  logic signed [rbd_pkg::DIST_W-1:0] dist_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign distance = dist_r;

  always_comb begin
    sum = $signed({up_data.off[rbd_pkg::OFF_W-1], up_data.off})
          + $signed({2'b00, up_data.root});
    if (sum[rbd_pkg::DIST_W] != sum[rbd_pkg::DIST_W-1]) begin
      dist_nxt = sum[rbd_pkg::DIST_W] ? {1'b1, {(rbd_pkg::DIST_W-1){1'b0}}}
                                      : {1'b0, {(rbd_pkg::DIST_W-1){1'b1}}};
    end else begin
      dist_nxt = sum[rbd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) dist_r <= dist_nxt;
  end

endmodule

FILE: verif/tb_rounded_box_distance_eval.sv
// Testbench for the rounded box signed distance evaluator: stream checks against a local predictor.
`timescale 1ns / 100ps

module tb_rounded_box_distance_eval;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  // addresses past the last register; writes there must be dropped
  localparam logic [rbd_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rbd_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [31:0]                       point;
    logic signed [rbd_pkg::DIST_W-1:0] distance;
  } dist_word_t;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_tvalid   = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata    = '0;   // pos_x[15:0], pos_y[31:16]
  logic                       out_tvalid;
  logic                       out_tready  = 1'b0;
  logic [23:0]                out_tdata;          // distance[17:0], zero[23:18]
  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [rbd_pkg::ADDR_W-1:0] cfg_paddr   = '0;
  logic [rbd_pkg::DATA_W-1:0] cfg_pwdata  = '0;
  logic [rbd_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  rbd_pkg::shape_cfg_t shape_model;
  logic [31:0] pending_points[$];
  dist_word_t  expected_dists[$];
  dist_word_t  exp_word;
  int          words_sent     = 0;
  int          words_checked  = 0;
  int          error_count    = 0;
  int          cycle_count    = 0;
  int          send_idle_max  = 0;
  int          recv_idle_max  = 0;
  int          send_wait      = 0;
  int          recv_wait      = 0;
  int          hold_left      = 0;
  bit          hold_request   = 1'b0;

  rounded_box_distance_eval DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [rbd_pkg::DIST_W-1:0] predict_distance(
    input logic signed [rbd_pkg::POS_W-1:0] x,
    input logic signed [rbd_pkg::POS_W-1:0] y
  );
    longint ax, ay, rad, hw, hh, qx, qy, inner, d;
    longint unsigned ex, ey;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    hw = shape_model.half_width;
    hh = shape_model.half_height;
    // zero on either axis falls to the left / lower corner
    if (x > 0) rad = (y > 0) ? shape_model.rad_ur : shape_model.rad_lr;
    else       rad = (y > 0) ? shape_model.rad_ul : shape_model.rad_ll;
    qx = ax - hw + rad;
    qy = ay - hh + rad;
    inner = (qx > qy) ? qx : qy;
    if (inner > 0) inner = 0;
    ex = (qx > 0) ? qx : 0;
    ey = (qy > 0) ? qy : 0;
    d = inner + longint'(floor_sqrt(ex * ex + ey * ey)) - rad;
    if (d > 131071) d = 131071;
    if (d < -131072) d = -131072;
    return rbd_pkg::DIST_W'(d);
  endfunction

  function automatic logic [rbd_pkg::REG_W-1:0] model_reg(
    input logic [rbd_pkg::IDX_W-1:0] idx
  );
    case (idx)
      rbd_pkg::REG_HALF_WIDTH:  return shape_model.half_width;
      rbd_pkg::REG_HALF_HEIGHT: return shape_model.half_height;
      rbd_pkg::REG_RAD_UR:      return shape_model.rad_ur;
      rbd_pkg::REG_RAD_LR:      return shape_model.rad_lr;
      rbd_pkg::REG_RAD_UL:      return shape_model.rad_ul;
      default:                  return shape_model.rad_ll;
    endcase
  endfunction

  task automatic reg_write(input logic [rbd_pkg::IDX_W-1:0] idx,
                           input logic [rbd_pkg::REG_W-1:0] value);
    logic [rbd_pkg::DATA_W-1:0] wdata;
    wdata = $urandom;
    if ($urandom_range(0, 1)) wdata[rbd_pkg::DATA_W-1:rbd_pkg::REG_W] = '0;
    wdata[rbd_pkg::REG_W-1:0] = value;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      rbd_pkg::REG_HALF_WIDTH:  shape_model.half_width  = value;
      rbd_pkg::REG_HALF_HEIGHT: shape_model.half_height = value;
      rbd_pkg::REG_RAD_UR:      shape_model.rad_ur      = value;
      rbd_pkg::REG_RAD_LR:      shape_model.rad_lr      = value;
      rbd_pkg::REG_RAD_UL:      shape_model.rad_ul      = value;
      rbd_pkg::REG_RAD_LL:      shape_model.rad_ll      = value;
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [rbd_pkg::IDX_W-1:0] idx);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[rbd_pkg::REG_W-1:0] !== model_reg(idx)) begin
      error_count++;
      $error("reg %0d readback: expected %0d, actual %0d",
             idx, model_reg(idx), cfg_prdata[rbd_pkg::REG_W-1:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    reg_check(rbd_pkg::REG_HALF_WIDTH);
    reg_check(rbd_pkg::REG_HALF_HEIGHT);
    reg_check(rbd_pkg::REG_RAD_UR);
    reg_check(rbd_pkg::REG_RAD_LR);
    reg_check(rbd_pkg::REG_RAD_UL);
    reg_check(rbd_pkg::REG_RAD_LL);
  endtask

  task automatic apply_shape(input rbd_pkg::shape_cfg_t s);
    reg_write(rbd_pkg::REG_HALF_WIDTH,  s.half_width);
    reg_write(rbd_pkg::REG_HALF_HEIGHT, s.half_height);
    reg_write(rbd_pkg::REG_RAD_UR,      s.rad_ur);
    reg_write(rbd_pkg::REG_RAD_LR,      s.rad_lr);
    reg_write(rbd_pkg::REG_RAD_UL,      s.rad_ul);
    reg_write(rbd_pkg::REG_RAD_LL,      s.rad_ll);
    reg_write(REG_SPARE_LO,             rbd_pkg::REG_W'($urandom));
    reg_write(REG_SPARE_HI,             rbd_pkg::REG_W'($urandom));
    check_all_regs();
  endtask

  task automatic push_point(input int x, input int y);
    pending_points.push_back({rbd_pkg::POS_W'(y), rbd_pkg::POS_W'(x)});
    words_sent++;
  endtask

  function automatic int pick_coord(input int extent);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($signed(rbd_pkg::POS_W'($urandom)));
      4, 5, 6: v = extent + int'($urandom_range(0, 2047)) - 1024;
      7, 8: v = int'($urandom_range(0, 8191));
      default: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 1;
          2: v = 32767;
          default: v = -32768;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic drain();
    while (words_checked != words_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n, input int smax, input int rmax);
    send_idle_max = smax;
    recv_idle_max = rmax;
    for (int i = 0; i < n; i++)
      push_point(pick_coord(shape_model.half_width), pick_coord(shape_model.half_height));
    drain();
  endtask

  function automatic rbd_pkg::shape_cfg_t random_shape(input int ext_max, input int rad_max);
    rbd_pkg::shape_cfg_t s;
    s.half_width  = rbd_pkg::REG_W'($urandom_range(0, ext_max));
    s.half_height = rbd_pkg::REG_W'($urandom_range(0, ext_max));
    s.rad_ur      = rbd_pkg::REG_W'($urandom_range(0, rad_max));
    s.rad_lr      = rbd_pkg::REG_W'($urandom_range(0, rad_max));
    s.rad_ul      = rbd_pkg::REG_W'($urandom_range(0, rad_max));
    s.rad_ll      = rbd_pkg::REG_W'($urandom_range(0, rad_max));
    return s;
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_dists.push_back('{point: in_tdata,
                                   distance: predict_distance(in_tdata[15:0],
                                                              in_tdata[31:16])});
      end
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          in_tvalid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_points.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_points.pop_front();
          send_wait <= $urandom_range(0, send_idle_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_dists.size() == 0) begin
          error_count++;
          $error("unexpected distance word %0d", $signed(out_tdata[rbd_pkg::DIST_W-1:0]));
        end else begin
          exp_word = expected_dists.pop_front();
          if (out_tdata[rbd_pkg::DIST_W-1:0] !== exp_word.distance) begin
            error_count++;
            $error("distance (x=%0d y=%0d): expected %0d, actual %0d",
                   $signed(exp_word.point[15:0]), $signed(exp_word.point[31:16]),
                   exp_word.distance, $signed(out_tdata[rbd_pkg::DIST_W-1:0]));
          end
          words_checked++;
        end
        recv_wait = $urandom_range(0, recv_idle_max);
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rbd_pkg::shape_cfg_t s;
    shape_model.half_width  = rbd_pkg::HALF_RESET;
    shape_model.half_height = rbd_pkg::HALF_RESET;
    shape_model.rad_ur      = '0;
    shape_model.rad_lr      = '0;
    shape_model.rad_ul      = '0;
    shape_model.rad_ll      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    check_all_regs();

    // reset shape: square with half extents 1.0 and radii 0
    push_point(0, 0);
    push_point(4096, 4096);
    push_point(-4096, -4096);
    push_point(32767, 32767);
    push_point(-32768, -32768);
    push_point(4096, 0);
    push_point(5000, 6000);
    push_point(-2000, 100);
    run_random(60, 0, 0);

    // one radius per quadrant, so the zero-axis selection shows
    s = '{half_width: 8192, half_height: 4096, rad_ur: 1000, rad_lr: 2000,
          rad_ul: 3000, rad_ll: 4000};
    apply_shape(s);
    push_point(0, 0);
    push_point(0, 4000);
    push_point(0, -4000);
    push_point(4000, 0);
    push_point(-4000, 0);
    push_point(9000, 5000);
    push_point(9000, -5000);
    push_point(-9000, 5000);
    push_point(-9000, -5000);
    push_point(1, 1);
    push_point(1, 0);
    push_point(0, 1);
    push_point(-1, -1);
    push_point(32767, 32767);
    push_point(-32768, -32768);
    push_point(32767, -32768);
    push_point(-32768, 32767);
    run_random(80, 16, 0);

    s = '{half_width: 0, half_height: 0, rad_ur: 0, rad_lr: 0, rad_ul: 0, rad_ll: 0};
    apply_shape(s);
    run_random(100, 0, 16);

    s = '{half_width: 32767, half_height: 32767, rad_ur: 32767, rad_lr: 32767,
          rad_ul: 32767, rad_ll: 32767};
    apply_shape(s);
    run_random(100, 16, 16);

    // radii far beyond the half extents
    s = '{half_width: 100, half_height: 50, rad_ur: 32767, rad_lr: 20000,
          rad_ul: 5000, rad_ll: 300};
    apply_shape(s);
    run_random(100, 3, 5);

    apply_shape(random_shape(20000, 8000));
    run_random(100, 2, 16);

    // long receiver hold while points keep coming
    apply_shape(random_shape(32767, 32767));
    hold_request = 1'b1;
    run_random(100, 0, 0);

    apply_shape(random_shape(16000, 4000));
    run_random(100, 16, 2);

    s = '{half_width: 3000, half_height: 12000, rad_ur: 0, rad_lr: 0, rad_ul: 0, rad_ll: 0};
    apply_shape(s);
    run_random(100, 1, 1);

    if (expected_dists.size() != 0) begin
      error_count++;
      $error("%0d distance words never arrived", expected_dists.size());
    end
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_front.sv
hw/rtl/rbd_sqrt_cell.sv
hw/rtl/rbd_tail.sv
hw/rtl/rounded_box_distance_eval.sv
verif/tb_rounded_box_distance_eval.sv
